[rtl/core/rsnl_pkg.sv]
package rsnl_pkg;

  localparam int CAPACITY  = 32;
  localparam int KEY_BYTES = 9;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SCORE_W = 10;
  localparam int SUM_W   = 11;
  localparam int TOTAL_W = 15;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 6;

  // Only the first KEY_BYTES bytes of a name are significant.
  localparam logic [63:0] REST_MASK = ~({64{1'b1}} >> (8 * (KEY_BYTES - 1)));

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SORT = 2'd1,
    OP_LOOK = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_SORTED  = 3'd2,
    ST_MATCH   = 3'd3,
    ST_NOMATCH = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_MARK,
    CELL_SORT,
    CELL_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    logic [7:0]  hi;
    logic [63:0] lo;
  } key_t;

  typedef struct packed {
    key_t               key;
    logic [SCORE_W-1:0] s1;
    logic [SCORE_W-1:0] s2;
  } rec_t;

  typedef struct packed {
    cell_cmd_e cmd;
    rec_t      load_rec;
    key_t      probe;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         key_first_byte;
    logic [63:0]        key_rest;
    logic [SCORE_W-1:0] first_score;
    logic [SCORE_W-1:0] second_score;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [POS_W-1:0]   position;
    logic [7:0]         out_key_first_byte;
    logic [63:0]        out_key_rest;
    logic [SCORE_W-1:0] out_first_score;
    logic [SCORE_W-1:0] out_second_score;
    logic [SUM_W-1:0]   pair_sum;
    logic [TOTAL_W-1:0] first_total;
    logic [TOTAL_W-1:0] second_total;
    logic [COUNT_W-1:0] record_count;
    logic               is_last;
  } out_word_t;

endpackage

[rtl/core/rsnl_cell.sv]
module rsnl_cell import rsnl_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      sel,
  input  logic      lead,
  input  logic      left_swap,
  input  rec_t      left_rec,
  input  rec_t      right_rec,
  input  logic      right_match,
  output rec_t      rec,
  output logic      match,
  output logic      swap
);

  rec_t rec_r, rec_nxt;
  logic match_r, match_nxt;

  // Swap only on strictly greater: equal names keep their order.
  assign swap = lead && (rec_r.key > right_rec.key);

  always_comb begin
    rec_nxt   = rec_r;
    match_nxt = match_r;
    unique case (ctl.cmd)
      CELL_HOLD: ;
      CELL_LOAD: begin
        if (sel) rec_nxt = ctl.load_rec;
      end
      CELL_MARK: begin
        match_nxt = sel && (rec_r.key == ctl.probe);
      end
      CELL_SORT: begin
        if (swap) rec_nxt = right_rec;
        else if (left_swap) rec_nxt = left_rec;
      end
      CELL_ROTATE: begin
        rec_nxt   = right_rec;
        match_nxt = right_match;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    match_r <= match_nxt;
  end

  assign rec   = rec_r;
  assign match = match_r;

endmodule

[rtl/core/record_sort_and_name_lookup_core.sv]
// Record table with stable name sort and name lookup, built as a row of
// CAPACITY cells, each holding one record in table order. A load (operation
// 0) writes the cell at the fill count in the cycle it is accepted, unless
// the table is full, when a full status word comes out; its word appears in
// the next cycle and busy stays low, so loads go one per cycle. A sort runs
// CAPACITY odd-even transposition phases over the row (each cell compares
// its name with its right neighbor and swaps on strictly greater, which
// keeps equal names in load order), then rotates the row once around,
// emitting cell 0 while its index is below the fill count. The last sorted
// word carries both score totals. A lookup marks matching cells in the
// accept cycle, counts them in a count state, then rotates the row once
// around emitting matches; with no match a single no-match word comes out
// and busy is high for one cycle. An empty sort and operation 3 produce
// nothing and leave busy low. Result words are shown for one cycle with
// out_valid and cannot be held off by the receiver.
module record_sort_and_name_lookup_core import rsnl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_SORT,
    S_EMIT,
    S_SCAN
  } state_e;

  state_e             state_r;
  logic [IDX_W-1:0]   phase_r;
  logic [IDX_W-1:0]   step_r;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   remain_r;
  logic [TOTAL_W-1:0] t1_r, t2_r;
  key_t               key_r;
  logic               out_valid_r;
  out_word_t          out_word_r;

  logic      accept;
  key_t      in_key;
  rec_t      in_rec;
  cell_ctl_t ctl;
  logic      full;

  rec_t              cell_rec [CAPACITY];
  logic [CAPACITY-1:0] match_vec, swap_vec, lead_vec, sel_vec;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (fill_r >= CNT_W'(CAPACITY));

  assign in_key.hi = in_word.key_first_byte;
  assign in_key.lo = in_word.key_rest & REST_MASK;
  assign in_rec.key = in_key;
  assign in_rec.s1  = in_word.first_score;
  assign in_rec.s2  = in_word.second_score;

  // Command broadcast to every cell.
  always_comb begin
    ctl.cmd      = CELL_HOLD;
    ctl.load_rec = in_rec;
    ctl.probe    = in_key;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_word.operation == OP_LOAD && !full) ctl.cmd = CELL_LOAD;
        else if (accept && in_word.operation == OP_LOOK) ctl.cmd = CELL_MARK;
      end
      S_COUNT: ctl.cmd = CELL_HOLD;
      S_SORT:  ctl.cmd = CELL_SORT;
      S_EMIT, S_SCAN: ctl.cmd = CELL_ROTATE;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int RIGHT = (g + 1) % CAPACITY;
    localparam int LEFT  = (g == 0) ? 0 : g - 1;
    logic valid, left_swap;

    assign valid = (CNT_W'(g) < fill_r);
    // Cell g leads pair (g, g+1) on phases of its own parity.
    assign lead_vec[g] = (((g % 2) == 1) == phase_r[0]) && (CNT_W'(g + 1) < fill_r);
    assign sel_vec[g]  = (ctl.cmd == CELL_LOAD) ? (CNT_W'(g) == fill_r) : valid;
    assign left_swap   = (g == 0) ? 1'b0 : swap_vec[LEFT];

    rsnl_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .sel         (sel_vec[g]),
      .lead        (lead_vec[g]),
      .left_swap   (left_swap),
      .left_rec    (cell_rec[LEFT]),
      .right_rec   (cell_rec[RIGHT]),
      .right_match (match_vec[RIGHT]),
      .rec         (cell_rec[g]),
      .match       (match_vec[g]),
      .swap        (swap_vec[g])
    );
  end

  // Head of the row: the record leaving cell 0 during a rotation.
  rec_t             head;
  logic             head_valid;
  logic [SUM_W-1:0] head_sum;
  logic             sort_last;

  assign head       = cell_rec[0];
  assign head_valid = (CNT_W'(step_r) < fill_r);
  assign head_sum   = SUM_W'(head.s1) + SUM_W'(head.s2);
  assign sort_last  = (CNT_W'(step_r) + CNT_W'(1) == fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      phase_r     <= '0;
      step_r      <= '0;
      remain_r    <= '0;
      t1_r        <= '0;
      t2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      // common fields of any word
      out_word_r.first_total  <= '0;
      out_word_r.second_total <= '0;
      out_word_r.record_count <= COUNT_W'(fill_r);
      out_word_r.is_last      <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r <= in_key;
            unique case (in_word.operation)
              OP_LOAD: begin
                out_valid_r                 <= 1'b1;
                out_word_r.out_key_first_byte <= in_key.hi;
                out_word_r.out_key_rest     <= in_key.lo;
                out_word_r.out_first_score  <= in_rec.s1;
                out_word_r.out_second_score <= in_rec.s2;
                out_word_r.pair_sum <= SUM_W'(in_rec.s1) + SUM_W'(in_rec.s2);
                if (!full) begin
                  fill_r                  <= fill_r + CNT_W'(1);
                  out_word_r.status       <= ST_LOADED;
                  out_word_r.position     <= POS_W'(fill_r);
                  out_word_r.record_count <= COUNT_W'(fill_r + CNT_W'(1));
                end else begin
                  out_word_r.status   <= ST_FULL;
                  out_word_r.position <= '0;
                end
              end
              OP_SORT: begin
                if (fill_r != '0) begin
                  state_r <= S_SORT;
                  phase_r <= '0;
                end
              end
              OP_LOOK: state_r <= S_COUNT;
              default: ;
            endcase
          end
        end
        S_COUNT: begin
          remain_r <= CNT_W'($countones(match_vec));
          step_r   <= '0;
          if (match_vec == '0) begin
            state_r                       <= S_IDLE;
            out_valid_r                   <= 1'b1;
            out_word_r.status             <= ST_NOMATCH;
            out_word_r.position           <= '0;
            out_word_r.out_key_first_byte <= key_r.hi;
            out_word_r.out_key_rest       <= key_r.lo;
            out_word_r.out_first_score    <= '0;
            out_word_r.out_second_score   <= '0;
            out_word_r.pair_sum           <= '0;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SORT: begin
          phase_r <= phase_r + IDX_W'(1);
          if (phase_r == IDX_W'(CAPACITY - 1)) begin
            state_r <= S_EMIT;
            step_r  <= '0;
            t1_r    <= '0;
            t2_r    <= '0;
          end
        end
        S_EMIT, S_SCAN: begin
          step_r <= step_r + IDX_W'(1);
          if (step_r == IDX_W'(CAPACITY - 1)) state_r <= S_IDLE;
          out_word_r.position           <= POS_W'(step_r);
          out_word_r.out_key_first_byte <= head.key.hi;
          out_word_r.out_key_rest       <= head.key.lo;
          out_word_r.out_first_score    <= head.s1;
          out_word_r.out_second_score   <= head.s2;
          out_word_r.pair_sum           <= head_sum;
          if (state_r == S_EMIT) begin
            out_word_r.status <= ST_SORTED;
            out_word_r.is_last <= sort_last;
            if (head_valid) begin
              out_valid_r <= 1'b1;
              t1_r <= t1_r + TOTAL_W'(head.s1);
              t2_r <= t2_r + TOTAL_W'(head.s2);
              if (sort_last) begin
                out_word_r.first_total  <= t1_r + TOTAL_W'(head.s1);
                out_word_r.second_total <= t2_r + TOTAL_W'(head.s2);
              end
            end
          end else begin
            out_word_r.status  <= ST_MATCH;
            out_word_r.is_last <= (remain_r == CNT_W'(1));
            if (head_valid && match_vec[0]) begin
              out_valid_r <= 1'b1;
              remain_r    <= remain_r - CNT_W'(1);
            end
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.operation == OP_LOAD && !full |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("load did not advance fill count");

  a_scan_remain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && head_valid && match_vec[0] |-> remain_r != '0)
    else $error("match emitted beyond counted matches");

  a_sorted_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_last && out_word.status == ST_SORTED
      |-> CNT_W'(out_word.position) + CNT_W'(1) == fill_r)
    else $error("last sorted word not at end of table");

endmodule
